// ----- src/assert_macros.svh -----
// Assertion macros shared by the sequencer RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/wcs_pkg.sv -----
// Types, constants and helper functions of the wash cycle sequencer.
// No dependencies; used by the channel interfaces and all modules.
`timescale 1ns / 1ps

package wcs_pkg;

	// Program stages as shown on the stage output
	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_FILL1  = 4'd1,
		ST_HEAT1  = 4'd2,
		ST_WASH   = 4'd3,
		ST_DRAIN1 = 4'd4,
		ST_FILL2  = 4'd5,
		ST_HEAT2  = 4'd6,
		ST_RINSE  = 4'd7,
		ST_DRAIN2 = 4'd8,
		ST_SPIN   = 4'd9,
		ST_DRAIN3 = 4'd10,
		ST_FINISH = 4'd11,
		ST_OFF    = 4'd12
	} stage_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_TOTAL_SECONDS = 3'd0,
		REG_TEMP_SETPOINT = 3'd1,
		REG_SPIN_LEVEL    = 3'd2,
		REG_LEVEL_FULL    = 3'd3,
		REG_LEVEL_EMPTY   = 3'd4
	} cfg_index_t;

	localparam logic [6:0]  CMP_STOP       = 7'd90;
	localparam logic [6:0]  CMP_WASH       = 7'd36;
	localparam logic [6:0]  CMP_RINSE      = 7'd25;
	localparam logic [6:0]  CMP_SPIN_END   = 7'd0;
	localparam logic [7:0]  REVERSE_PERIOD = 8'd3;
	localparam logic [11:0] LEVEL_FULL_RST  = 12'd2000;
	localparam logic [11:0] LEVEL_EMPTY_RST = 12'd100;
	// 205/1024 approximates 1/5 exactly for dividends below 1024
	localparam logic [7:0]  DIV5_RECIP     = 8'd205;

	typedef struct packed {
		logic               start_req;
		logic        [11:0] water_level;
		logic signed [11:0] water_temp_tenths;
	} tick_word_t;

	typedef struct packed {
		logic [3:0] stage;
		logic [7:0] seconds_left;
		logic       motor_forward;
		logic       motor_reverse;
		logic [6:0] motor_compare;
		logic       heater_on;
		logic       pump_on;
		logic       power_off;
		logic       beep;
	} result_word_t;

	typedef struct packed {
		logic [7:0]  total_seconds;
		logic [6:0]  temp_setpoint;
		logic [2:0]  spin_level;
		logic [11:0] level_full;
		logic [11:0] level_empty;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		total_seconds: 8'd0,
		temp_setpoint: 7'd0,
		spin_level:    3'd0,
		level_full:    LEVEL_FULL_RST,
		level_empty:   LEVEL_EMPTY_RST
	};

	typedef struct packed {
		stage_t     stage;
		logic [7:0] secs_left;
		logic [7:0] wash_len;
		logic [7:0] rinse_len;
		logic [7:0] spin_left;
		logic [7:0] phase_count;
		logic [7:0] pause_at;
		logic       reverse_dir;
		logic       motor_forward;
		logic       motor_reverse;
		logic [6:0] motor_compare;
		logic       heater_on;
		logic       pump_on;
	} seq_state_t;

	localparam seq_state_t SEQ_RESET = '{
		stage:         ST_IDLE,
		secs_left:     8'd0,
		wash_len:      8'd0,
		rinse_len:     8'd0,
		spin_left:     8'd0,
		phase_count:   8'd0,
		pause_at:      REVERSE_PERIOD,
		reverse_dir:   1'b0,
		motor_forward: 1'b0,
		motor_reverse: 1'b0,
		motor_compare: CMP_STOP,
		heater_on:     1'b0,
		pump_on:       1'b0
	};

	// Spin duty per speed level; unused levels stop the drum
	function automatic logic [6:0] spin_compare(input logic [2:0] level);
		logic [6:0] cmp;
		case (level)
			3'd0: cmp = 7'd90;
			3'd1: cmp = 7'd16;
			3'd2: cmp = 7'd12;
			3'd3: cmp = 7'd8;
			3'd4: cmp = 7'd4;
			3'd5: cmp = 7'd0;
			default: cmp = CMP_STOP;
		endcase
		return cmp;
	endfunction

endpackage

// ----- src/wcs_channels.sv -----
// Valid/ready channel interfaces of the wash cycle sequencer.
// Depends on wcs_pkg for the payload types.
`timescale 1ns / 1ps

interface wcs_tick_if;
	logic                valid;
	logic                ready;
	wcs_pkg::tick_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wcs_result_if;
	logic                  valid;
	logic                  ready;
	wcs_pkg::result_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wcs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [11:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- src/wcs_step.sv -----
// Next-state logic of the sequencer for one tick word.
// Depends on wcs_pkg; purely combinational, registered by the top level.
`timescale 1ns / 1ps

module wcs_step (
	input  wcs_pkg::seq_state_t cur,
	input  wcs_pkg::cfg_t       cfg,
	input  wcs_pkg::tick_word_t word,
	output wcs_pkg::seq_state_t nxt
);
	import wcs_pkg::*;

	logic [9:0]         total_x3;
	logic [17:0]        split_prod;
	logic [7:0]         wash_split;
	logic [7:0]         rinse_split;
	logic [7:0]         spin_split;
	logic [10:0]        sp_x10;
	logic signed [12:0] temp_ext;
	logic               heat_done;
	logic [7:0]         secs_dec;
	logic [7:0]         spin_after;
	logic [7:0]         pc_inc;
	logic [7:0]         agit_len;
	logic [6:0]         agit_cmp;
	stage_t             agit_next;
	stage_t             drain_next;

	// Split total time: 3/5 wash, 3/10 rinse, rest spin
	assign total_x3    = {2'b00, cfg.total_seconds} + {1'b0, cfg.total_seconds, 1'b0};
	assign split_prod  = {8'b0, total_x3} * {10'b0, DIV5_RECIP};
	assign wash_split  = split_prod[17:10];
	assign rinse_split = {1'b0, split_prod[17:11]};
	assign spin_split  = cfg.total_seconds - wash_split - rinse_split;

	// Heat ends once the water is above the setpoint
	assign sp_x10    = {1'b0, cfg.temp_setpoint, 3'b000} + {3'b000, cfg.temp_setpoint, 1'b0};
	assign temp_ext  = {word.water_temp_tenths[11], word.water_temp_tenths};
	assign heat_done = temp_ext > $signed({2'b00, sp_x10});

	// Saturating second and spin counters
	assign secs_dec   = (cur.secs_left != 8'd0) ? cur.secs_left - 8'd1 : 8'd0;
	assign spin_after = (cur.spin_left != 8'd0) ? cur.spin_left - 8'd1 : 8'd0;

	// Agitation parameters for wash or rinse
	assign pc_inc    = cur.phase_count + 8'd1;
	assign agit_len  = (cur.stage == ST_WASH) ? cur.wash_len : cur.rinse_len;
	assign agit_cmp  = (cur.stage == ST_WASH) ? CMP_WASH : CMP_RINSE;
	assign agit_next = (cur.stage == ST_WASH) ? ST_DRAIN1 : ST_DRAIN2;

	always_comb begin
		case (cur.stage)
			ST_DRAIN1: drain_next = ST_FILL2;
			ST_DRAIN2: drain_next = ST_SPIN;
			default:   drain_next = ST_FINISH;
		endcase
	end

	always_comb begin
		nxt = cur;
		case (cur.stage)
			ST_IDLE: begin
				if (word.start_req) begin
					nxt.wash_len  = wash_split;
					nxt.rinse_len = rinse_split;
					nxt.spin_left = spin_split;
					nxt.secs_left = cfg.total_seconds;
					nxt.stage     = ST_FILL1;
				end
			end
			ST_FILL1: begin
				if (word.water_level > cfg.level_full) nxt.stage = ST_HEAT1;
			end
			ST_FILL2: begin
				if (word.water_level > cfg.level_full) nxt.stage = ST_HEAT2;
			end
			ST_HEAT1, ST_HEAT2: begin
				if (!heat_done) begin
					nxt.heater_on = 1'b1;
				end else begin
					nxt.heater_on   = 1'b0;
					nxt.stage       = (cur.stage == ST_HEAT1) ? ST_WASH : ST_RINSE;
					nxt.phase_count = 8'd0;
					nxt.pause_at    = REVERSE_PERIOD;
					nxt.reverse_dir = 1'b0;
				end
			end
			ST_WASH, ST_RINSE: begin
				if (agit_len == 8'd0) begin
					// Empty phase: stop and move on without taking a second
					nxt.motor_forward = 1'b0;
					nxt.motor_reverse = 1'b0;
					nxt.motor_compare = CMP_STOP;
					nxt.stage         = agit_next;
				end else begin
					nxt.phase_count = pc_inc;
					if (pc_inc == agit_len) begin
						nxt.motor_forward = 1'b0;
						nxt.motor_reverse = 1'b0;
						nxt.motor_compare = CMP_STOP;
						nxt.stage         = agit_next;
					end else if (pc_inc < cur.pause_at) begin
						nxt.motor_forward = !cur.reverse_dir;
						nxt.motor_reverse = cur.reverse_dir;
						nxt.motor_compare = agit_cmp;
					end else if (pc_inc == cur.pause_at) begin
						// Pause one second, then reverse
						nxt.motor_forward = 1'b0;
						nxt.motor_reverse = 1'b0;
						nxt.motor_compare = CMP_STOP;
						nxt.reverse_dir   = !cur.reverse_dir;
						nxt.pause_at      = pc_inc + REVERSE_PERIOD;
					end
					nxt.secs_left = secs_dec;
				end
			end
			ST_DRAIN1, ST_DRAIN2, ST_DRAIN3: begin
				// Pump hysteresis between the full and empty marks
				if (word.water_level > cfg.level_full) begin
					nxt.pump_on = 1'b1;
				end else if (word.water_level < cfg.level_empty) begin
					nxt.pump_on = 1'b0;
					nxt.stage   = drain_next;
				end
			end
			ST_SPIN: begin
				nxt.motor_forward = 1'b1;
				nxt.motor_reverse = 1'b0;
				nxt.motor_compare = spin_compare(cfg.spin_level);
				if (cur.spin_left != 8'd0) begin
					nxt.spin_left = spin_after;
					nxt.secs_left = secs_dec;
				end
				if (spin_after == 8'd0) begin
					nxt.motor_forward = 1'b0;
					nxt.motor_reverse = 1'b0;
					nxt.motor_compare = CMP_SPIN_END;
					nxt.stage         = ST_DRAIN3;
				end
			end
			ST_FINISH: nxt.stage = ST_OFF;
			ST_OFF: ;
			default: nxt.stage = ST_IDLE;
		endcase
	end

endmodule

// ----- src/wash_cycle_sequencer.sv -----
// Top level of the wash cycle sequencer: config registers, state, output register.
// Depends on wcs_pkg, wcs_channels, wcs_step and assert_macros.svh.
//
//   channel  dir   word                          handshake
//   tick     in    start_req, level, temp        valid/ready
//   result   out   stage, seconds, actuators     valid/ready
//   cfg      in    index, wdata (5 registers)    valid/ready, always ready
//
// One tick word is taken per clock while the result is not stalled; its result is ready the next cycle.
// The state register and the result valid flag form a single stage, so a new
// tick is taken whenever the result register is empty or being taken.
// A stalled result holds and blocks only further ticks.
// Reset: idle stage, all actuators off, motor compare 90, level marks 2000/100.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wash_cycle_sequencer (
	input logic          clk,
	input logic          arst_n,
	wcs_tick_if.sink     tick,
	wcs_result_if.source result,
	wcs_cfg_if.sink      cfg
);
	import wcs_pkg::*;

	seq_state_t state_q;
	seq_state_t state_nxt;
	cfg_t       cfg_q;
	logic       out_valid_q;
	logic       accept;

	// Take a tick whenever the result slot frees up
	assign tick.ready = !out_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	wcs_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.word (tick.data),
		.nxt  (state_nxt)
	);

	// Write configuration registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TOTAL_SECONDS: cfg_q.total_seconds <= cfg.wdata[7:0];
				REG_TEMP_SETPOINT: cfg_q.temp_setpoint <= cfg.wdata[6:0];
				REG_SPIN_LEVEL:    cfg_q.spin_level    <= cfg.wdata[2:0];
				REG_LEVEL_FULL:    cfg_q.level_full    <= cfg.wdata;
				REG_LEVEL_EMPTY:   cfg_q.level_empty   <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Advance program state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word comes straight from the updated state
	assign result.valid              = out_valid_q;
	assign result.data.stage         = state_q.stage;
	assign result.data.seconds_left  = state_q.secs_left;
	assign result.data.motor_forward = state_q.motor_forward;
	assign result.data.motor_reverse = state_q.motor_reverse;
	assign result.data.motor_compare = state_q.motor_compare;
	assign result.data.heater_on     = state_q.heater_on;
	assign result.data.pump_on       = state_q.pump_on;
	assign result.data.power_off     = (state_q.stage == ST_OFF);
	assign result.data.beep          = (state_q.stage == ST_OFF);

	// Checks on the sequencer's own state
	`ASSERT_CLK(a_motor_one_way, !(state_q.motor_forward && state_q.motor_reverse), "motor driven both ways")
	`ASSERT_IMPL(a_heater_in_heat, state_q.heater_on, (state_q.stage == ST_HEAT1) || (state_q.stage == ST_HEAT2), "heater on outside heat stage")
	`ASSERT_NEXT(a_secs_no_rise, accept && (state_q.stage != ST_IDLE), state_q.secs_left <= $past(state_q.secs_left), "seconds left rose mid program")
	`ASSERT_NEXT(a_off_holds, state_q.stage == ST_OFF, state_q.stage == ST_OFF, "left the off stage")

endmodule
